### hdl/hwbc_pkg.sv
// hwbc_pkg: shared types and constants of the half-wave bit classifier
// no dependencies; used by the register file, classifier, top level and checker
`timescale 1ns / 1ps

package hwbc_pkg;

    // fixed field widths
    localparam int THR_W    = 16;
    localparam int SUM_W    = 18;
    localparam int IN_W     = 16;
    localparam int CFG_W    = 18;
    localparam int IDX_W    = 3;
    localparam int WIN_SIZE = 4;

    // result kinds
    typedef enum logic [1:0] {
        KIND_ZERO = 2'd0,
        KIND_ONE  = 2'd1,
        KIND_GAP  = 2'd2
    } kind_t;

    // configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_ONE_BAND_MIN  = 3'd0,
        REG_ONE_SHORT_LIM = 3'd1,
        REG_ONE_BAND_MAX  = 3'd2,
        REG_ZERO_BAND_MIN = 3'd3,
        REG_ZERO_LONG_MIN = 3'd4,
        REG_ZERO_BAND_MAX = 3'd5,
        REG_TOTAL_MIN     = 3'd6,
        REG_TOTAL_MAX     = 3'd7
    } reg_index_t;

    // reset values of the thresholds
    localparam logic [THR_W-1:0] ONE_BAND_MIN_RST  = 16'd250;
    localparam logic [THR_W-1:0] ONE_SHORT_LIM_RST = 16'd550;
    localparam logic [THR_W-1:0] ONE_BAND_MAX_RST  = 16'd600;
    localparam logic [THR_W-1:0] ZERO_BAND_MIN_RST = 16'd490;
    localparam logic [THR_W-1:0] ZERO_LONG_MIN_RST = 16'd680;
    localparam logic [THR_W-1:0] ZERO_BAND_MAX_RST = 16'd1100;
    localparam logic [SUM_W-1:0] TOTAL_MIN_RST     = 18'd1250;
    localparam logic [SUM_W-1:0] TOTAL_MAX_RST     = 18'd2100;

    // threshold set seen by the classifier
    typedef struct packed {
        logic [THR_W-1:0] one_band_min;
        logic [THR_W-1:0] one_short_lim;
        logic [THR_W-1:0] one_band_max;
        logic [THR_W-1:0] zero_band_min;
        logic [THR_W-1:0] zero_long_min;
        logic [THR_W-1:0] zero_band_max;
        logic [SUM_W-1:0] total_min;
        logic [SUM_W-1:0] total_max;
    } cfg_t;

    // one classified symbol
    typedef struct packed {
        kind_t            kind;
        logic [SUM_W-1:0] length;
    } symbol_t;

endpackage

### hdl/hwbc_cfg_regs.sv
// hwbc_cfg_regs: threshold register file written over the configuration channel
// depends on hwbc_pkg
`timescale 1ns / 1ps

module hwbc_cfg_regs
    import hwbc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;

    // register writes, reset to the default bands
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.one_band_min  <= ONE_BAND_MIN_RST;
            cfg_reg.one_short_lim <= ONE_SHORT_LIM_RST;
            cfg_reg.one_band_max  <= ONE_BAND_MAX_RST;
            cfg_reg.zero_band_min <= ZERO_BAND_MIN_RST;
            cfg_reg.zero_long_min <= ZERO_LONG_MIN_RST;
            cfg_reg.zero_band_max <= ZERO_BAND_MAX_RST;
            cfg_reg.total_min     <= TOTAL_MIN_RST;
            cfg_reg.total_max     <= TOTAL_MAX_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_ONE_BAND_MIN:  cfg_reg.one_band_min  <= cfg_data[THR_W-1:0];
                REG_ONE_SHORT_LIM: cfg_reg.one_short_lim <= cfg_data[THR_W-1:0];
                REG_ONE_BAND_MAX:  cfg_reg.one_band_max  <= cfg_data[THR_W-1:0];
                REG_ZERO_BAND_MIN: cfg_reg.zero_band_min <= cfg_data[THR_W-1:0];
                REG_ZERO_LONG_MIN: cfg_reg.zero_long_min <= cfg_data[THR_W-1:0];
                REG_ZERO_BAND_MAX: cfg_reg.zero_band_max <= cfg_data[THR_W-1:0];
                REG_TOTAL_MIN:     cfg_reg.total_min     <= cfg_data[SUM_W-1:0];
                REG_TOTAL_MAX:     cfg_reg.total_max     <= cfg_data[SUM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### hdl/hwbc_classify.sv
// hwbc_classify: compare network that sorts a full window into zero, one or gap
// depends on hwbc_pkg
`timescale 1ns / 1ps

module hwbc_classify
    import hwbc_pkg::*;
#(
    parameter int LEN_W = 16
) (
    input  logic [WIN_SIZE-1:0][LEN_W-1:0] wave,
    input  cfg_t                           cfg,
    output symbol_t                        symbol
);

    logic [THR_W-1:0] w_thr [WIN_SIZE];
    logic [SUM_W-1:0] w_sum [WIN_SIZE];
    logic [SUM_W-1:0] pair_sum;
    logic [SUM_W-1:0] quad_sum;
    logic             pair_in_band;
    logic             quad_in_band;
    logic             zero_a;
    logic             zero_b;
    logic [WIN_SIZE-1:0] thin;
    logic [WIN_SIZE-1:0] outside;

    // widen each half-wave for threshold and sum compares
    always_comb begin
        for (int i = 0; i < WIN_SIZE; i++) begin
            w_thr[i] = THR_W'(wave[i]);
            w_sum[i] = SUM_W'(wave[i]);
        end
    end

    // sums never overflow 18 bits since half-waves are at most 16 bits
    assign pair_sum = w_sum[0] + w_sum[1];
    assign quad_sum = (w_sum[0] + w_sum[1]) + (w_sum[2] + w_sum[3]);

    assign pair_in_band = (pair_sum >= cfg.total_min) && (pair_sum < cfg.total_max);
    assign quad_in_band = (quad_sum >= cfg.total_min) && (quad_sum < cfg.total_max);

    // zero: one long half-wave and one partner in the zero band, either order
    assign zero_a = (w_thr[0] >= cfg.zero_long_min) && (w_thr[1] >= cfg.zero_band_min)
                    && (w_thr[1] < cfg.zero_band_max);
    assign zero_b = (w_thr[1] >= cfg.zero_long_min) && (w_thr[0] >= cfg.zero_band_min)
                    && (w_thr[0] < cfg.zero_band_max);

    // one: per half-wave thin and out-of-band flags
    always_comb begin
        for (int i = 0; i < WIN_SIZE; i++) begin
            thin[i]    = w_thr[i] < cfg.one_short_lim;
            outside[i] = (w_thr[i] < cfg.one_band_min) || (w_thr[i] >= cfg.one_band_max);
        end
    end

    // priority: zero, then one, then gap
    always_comb begin
        if (pair_in_band && (zero_a || zero_b)) begin
            symbol.kind   = KIND_ZERO;
            symbol.length = pair_sum;
        end else if (quad_in_band && (|thin) && !(|outside)) begin
            symbol.kind   = KIND_ONE;
            symbol.length = quad_sum;
        end else begin
            symbol.kind   = KIND_GAP;
            symbol.length = w_sum[0];
        end
    end

endmodule

### hdl/tape_half_wave_bit_classifier.sv
// tape_half_wave_bit_classifier: top level with input register, window and result register
// depends on hwbc_pkg, hwbc_cfg_regs and hwbc_classify
`timescale 1ns / 1ps

// Decodes 1200 baud tape data from measured half-wave lengths. Each accepted
// half-wave length enters a four-entry window; each half-wave that brings the
// window to four entries yields one symbol (data zero, data one or gap)
// together with the summed length of the half-waves it used, which then leave
// the window. The block takes one half-wave per cycle unless a stalled result
// holds it back; a symbol shows on the m_ ports once the half-wave that
// completed it has passed through the input register, where the window compare
// network works on it, and the result register has loaded the symbol. A stalled
// result holds the input side only once the input register is also waiting on
// a window-filling half-wave. Thresholds are to be written over the cfg_
// channel only while the block is idle; the block itself does not enforce it.
// They come out of reset at the standard band limits.
module tape_half_wave_bit_classifier
    import hwbc_pkg::*;
#(
    parameter int LENGTH_BITS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [IN_W-1:0]  s_half_wave_length,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_symbol_kind,
    output logic [SUM_W-1:0] m_symbol_length,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int LEN_W  = (LENGTH_BITS < IN_W) ? LENGTH_BITS : IN_W;
    localparam int FILL_W = $clog2(WIN_SIZE);

    typedef logic [WIN_SIZE-1:0][LEN_W-1:0] window_t;

    cfg_t             cfg;
    logic [LEN_W-1:0] sat_len;
    logic             in_valid_reg;
    logic [LEN_W-1:0] in_len_reg;
    window_t          win_reg;
    window_t          win_next;
    window_t          cand;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic             is_full;
    logic             out_free;
    logic             advance;
    symbol_t          symbol;
    logic             m_valid_reg;
    symbol_t          out_reg;

    assign cfg_ready = 1'b1;

    hwbc_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // clamp inputs that exceed the length range
    generate
        if (LENGTH_BITS < IN_W) begin : g_sat
            assign sat_len = (|s_half_wave_length[IN_W-1:LENGTH_BITS]) ? {LEN_W{1'b1}}
                                                   : s_half_wave_length[LEN_W-1:0];
        end else begin : g_nosat
            assign sat_len = s_half_wave_length;
        end
    endgenerate

    // pipeline control
    assign is_full  = (fill_reg == FILL_W'(WIN_SIZE - 1));
    assign out_free = !m_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!is_full || out_free);
    assign s_ready  = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_len_reg <= sat_len;
        end
    end

    // window with the registered half-wave placed at the fill position
    always_comb begin
        for (int i = 0; i < WIN_SIZE; i++) begin
            cand[i] = (FILL_W'(i) == fill_reg) ? in_len_reg : win_reg[i];
        end
    end

    hwbc_classify #(
        .LEN_W (LEN_W)
    ) u_classify (
        .wave   (cand),
        .cfg    (cfg),
        .symbol (symbol)
    );

    // consume from the front of a full window, vacated entries cleared
    always_comb begin
        win_next  = cand;
        fill_next = fill_reg + FILL_W'(1);
        if (is_full) begin
            case (symbol.kind)
                KIND_ZERO: begin
                    win_next  = '0;
                    win_next[0] = cand[2];
                    win_next[1] = cand[3];
                    fill_next = FILL_W'(2);
                end
                KIND_ONE: begin
                    win_next  = '0;
                    fill_next = '0;
                end
                default: begin
                    win_next  = '0;
                    win_next[0] = cand[1];
                    win_next[1] = cand[2];
                    win_next[2] = cand[3];
                    fill_next = FILL_W'(WIN_SIZE - 1);
                end
            endcase
        end
    end

    // window state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            win_reg  <= '0;
        end else if (advance) begin
            fill_reg <= fill_next;
            win_reg  <= win_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && is_full) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && is_full) begin
            out_reg <= symbol;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_symbol_kind   = out_reg.kind;
    assign m_symbol_length = out_reg.length;

endmodule

### hdl/hwbc_checker.sv
// hwbc_checker: port-level assertions for the half-wave bit classifier, bound to the top level
// depends on hwbc_pkg and tape_half_wave_bit_classifier
`timescale 1ns / 1ps

module hwbc_checker
    import hwbc_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             m_valid,
    input logic             m_ready,
    input logic [1:0]       m_symbol_kind,
    input logic [SUM_W-1:0] m_symbol_length
);

    // a stalled result request holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_symbol_kind) && $stable(m_symbol_length))
        else $error("result changed while stalled");

    // no result comes out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a gap carries a single half-wave length
    a_gap_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_symbol_kind == KIND_GAP) |-> (m_symbol_length[SUM_W-1:IN_W] == '0))
        else $error("gap length wider than one half-wave");

    // a zero carries the sum of two half-waves
    a_zero_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_symbol_kind == KIND_ZERO) |-> !m_symbol_length[SUM_W-1])
        else $error("zero length wider than two half-waves");

endmodule

bind tape_half_wave_bit_classifier hwbc_checker u_hwbc_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_symbol_kind   (m_symbol_kind),
    .m_symbol_length (m_symbol_length)
);

### dv/testbench.sv
// testbench: self-checking bench for tape_half_wave_bit_classifier
// depends on hwbc_pkg and the block's rtl; directed rows, then random bit streams under threshold sets
`timescale 1ns / 1ps

module testbench;
    import hwbc_pkg::*;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic [IN_W-1:0]  s_half_wave_length;
    logic             m_valid;
    logic             m_ready;
    logic [1:0]       m_symbol_kind;
    logic [SUM_W-1:0] m_symbol_length;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    // directed row: a half-wave length and, where obvious, the symbol it completes
    typedef struct packed {
        logic [IN_W-1:0]  len;
        logic             checked;
        kind_t            kind;
        logic [SUM_W-1:0] length;
    } wave_row_t;

    localparam int DIRECTED_ROWS = 23;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_WAVES   = 55;
    localparam int SETTLE_CYCLES = 8;

    wave_row_t directed_rows [DIRECTED_ROWS] = '{
        '{16'd700,   1'b0, KIND_GAP,  18'd0},
        '{16'd600,   1'b0, KIND_GAP,  18'd0},
        '{16'd0,     1'b0, KIND_GAP,  18'd0},
        '{16'd0,     1'b1, KIND_ZERO, 18'd1300},
        '{16'd65535, 1'b0, KIND_GAP,  18'd0},
        '{16'd65535, 1'b1, KIND_GAP,  18'd0},
        '{16'd400,   1'b0, KIND_GAP,  18'd0},
        '{16'd400,   1'b0, KIND_GAP,  18'd0},
        '{16'd400,   1'b0, KIND_GAP,  18'd0},
        '{16'd400,   1'b1, KIND_ONE,  18'd1600},
        '{16'd500,   1'b0, KIND_GAP,  18'd0},
        '{16'd500,   1'b0, KIND_GAP,  18'd0},
        '{16'd500,   1'b0, KIND_GAP,  18'd0},
        '{16'd599,   1'b1, KIND_ONE,  18'd2099},
        '{16'd525,   1'b0, KIND_GAP,  18'd0},
        '{16'd525,   1'b0, KIND_GAP,  18'd0},
        '{16'd525,   1'b0, KIND_GAP,  18'd0},
        '{16'd525,   1'b1, KIND_GAP,  18'd525},
        '{16'd1100,  1'b0, KIND_GAP,  18'd0},
        '{16'd680,   1'b0, KIND_GAP,  18'd0},
        '{16'd0,     1'b0, KIND_GAP,  18'd0},
        '{16'd1099,  1'b0, KIND_GAP,  18'd0},
        '{16'd489,   1'b0, KIND_GAP,  18'd0}
    };

    // classifier shadow state
    cfg_t            thr;
    logic [IN_W-1:0] wave_win [WIN_SIZE];
    int              wave_count;
    symbol_t         pending_symbols [$];
    symbol_t         last_symbol;
    int              symbol_count;
    int              error_count;

    // idle knobs for the two sides
    int send_idle_pct;
    int recv_stall_pct;

    tape_half_wave_bit_classifier dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_half_wave_length (s_half_wave_length),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_symbol_kind      (m_symbol_kind),
        .m_symbol_length    (m_symbol_length),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("FAIL tape_half_wave_bit_classifier");
        $finish;
    end

    function automatic logic in_total_band(input logic [SUM_W-1:0] s);
        return s >= thr.total_min && s < thr.total_max;
    endfunction

    function automatic logic zero_pair(input logic [IN_W-1:0] lng, input logic [IN_W-1:0] partner);
        return lng >= thr.zero_long_min && partner >= thr.zero_band_min &&
               partner < thr.zero_band_max;
    endfunction

    // shift a half-wave into the window and predict the symbol a full window gives
    task automatic classify_half_wave(input logic [IN_W-1:0] len);
        logic [SUM_W-1:0] pair;
        logic [SUM_W-1:0] quad;
        logic             thin_seen;
        logic             out_of_band;
        int               take;
        symbol_t          sym;
        if (wave_count < WIN_SIZE) begin
            wave_win[wave_count] = len;
            wave_count++;
        end
        if (wave_count < WIN_SIZE) return;
        pair = SUM_W'(wave_win[0]) + SUM_W'(wave_win[1]);
        quad = pair + SUM_W'(wave_win[2]) + SUM_W'(wave_win[3]);
        thin_seen   = 1'b0;
        out_of_band = 1'b0;
        for (int i = 0; i < WIN_SIZE; i++) begin
            if (wave_win[i] < thr.one_short_lim) thin_seen = 1'b1;
            if (wave_win[i] < thr.one_band_min || wave_win[i] >= thr.one_band_max)
                out_of_band = 1'b1;
        end
        if (in_total_band(pair) &&
            (zero_pair(wave_win[0], wave_win[1]) || zero_pair(wave_win[1], wave_win[0]))) begin
            sym.kind   = KIND_ZERO;
            sym.length = pair;
            take       = 2;
        end else if (in_total_band(quad) && thin_seen && !out_of_band) begin
            sym.kind   = KIND_ONE;
            sym.length = quad;
            take       = 4;
        end else begin
            sym.kind   = KIND_GAP;
            sym.length = SUM_W'(wave_win[0]);
            take       = 1;
        end
        pending_symbols.push_back(sym);
        last_symbol = sym;
        symbol_count++;
        for (int i = 0; i < WIN_SIZE; i++)
            wave_win[i] = (i + take < WIN_SIZE) ? wave_win[i + take] : '0;
        wave_count -= take;
    endtask

    // watch accepted requests on all three channels
    always @(posedge aclk) begin : watch
        symbol_t exp_sym;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_symbols.size() == 0) begin
                    $error("unexpected symbol kind %0d length %0d",
                           m_symbol_kind, m_symbol_length);
                    error_count++;
                end else begin
                    exp_sym = pending_symbols.pop_front();
                    if (m_symbol_kind !== exp_sym.kind) begin
                        $error("symbol_kind expected %0d actual %0d",
                               exp_sym.kind, m_symbol_kind);
                        error_count++;
                    end
                    if (m_symbol_length !== exp_sym.length) begin
                        $error("symbol_length expected %0d actual %0d",
                               exp_sym.length, m_symbol_length);
                        error_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (reg_index_t'(cfg_index))
                    REG_ONE_BAND_MIN:  thr.one_band_min  = cfg_data[THR_W-1:0];
                    REG_ONE_SHORT_LIM: thr.one_short_lim = cfg_data[THR_W-1:0];
                    REG_ONE_BAND_MAX:  thr.one_band_max  = cfg_data[THR_W-1:0];
                    REG_ZERO_BAND_MIN: thr.zero_band_min = cfg_data[THR_W-1:0];
                    REG_ZERO_LONG_MIN: thr.zero_long_min = cfg_data[THR_W-1:0];
                    REG_ZERO_BAND_MAX: thr.zero_band_max = cfg_data[THR_W-1:0];
                    REG_TOTAL_MIN:     thr.total_min     = cfg_data;
                    REG_TOTAL_MAX:     thr.total_max     = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) classify_half_wave(s_half_wave_length);
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // random length in [lo, hi] clamped to the field, lo when the range is empty
    function automatic logic [IN_W-1:0] pick(input int lo, input int hi);
        if (lo < 0) lo = 0;
        if (hi > 65535) hi = 65535;
        if (lo > 65535) lo = 65535;
        if (hi < lo) return IN_W'(lo);
        return IN_W'($urandom_range(hi, lo));
    endfunction

    // offer one half-wave; called and returns at a falling edge, valid left high
    task automatic push_wave(input logic [IN_W-1:0] len);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid            <= 1'b1;
        s_half_wave_length <= len;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // hold the input side until every symbol is out, then let the pipe settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_symbols.size() > 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // write all eight thresholds for one setting
    task automatic load_thresholds(input int setting);
        logic [CFG_W-1:0] vals [8];
        vals[REG_ONE_BAND_MIN]  = ONE_BAND_MIN_RST;
        vals[REG_ONE_SHORT_LIM] = ONE_SHORT_LIM_RST;
        vals[REG_ONE_BAND_MAX]  = ONE_BAND_MAX_RST;
        vals[REG_ZERO_BAND_MIN] = ZERO_BAND_MIN_RST;
        vals[REG_ZERO_LONG_MIN] = ZERO_LONG_MIN_RST;
        vals[REG_ZERO_BAND_MAX] = ZERO_BAND_MAX_RST;
        vals[REG_TOTAL_MIN]     = TOTAL_MIN_RST;
        vals[REG_TOTAL_MAX]     = TOTAL_MAX_RST;
        case (setting)
            // jitter around the standard limits
            1: begin
                for (int i = 0; i < 6; i++)
                    vals[i] = CFG_W'(pick(int'(vals[i]) - 50, int'(vals[i]) + 50));
                vals[REG_TOTAL_MIN] = CFG_W'($urandom_range(1350, 1150));
                vals[REG_TOTAL_MAX] = CFG_W'($urandom_range(2200, 2000));
            end
            // every band wide open
            2: begin
                vals[REG_ONE_BAND_MIN]  = '0;
                vals[REG_ONE_SHORT_LIM] = CFG_W'(16'hFFFF);
                vals[REG_ONE_BAND_MAX]  = CFG_W'(16'hFFFF);
                vals[REG_ZERO_BAND_MIN] = '0;
                vals[REG_ZERO_LONG_MIN] = '0;
                vals[REG_ZERO_BAND_MAX] = CFG_W'(16'hFFFF);
                vals[REG_TOTAL_MIN]     = '0;
                vals[REG_TOTAL_MAX]     = '1;
            end
            3: for (int i = 0; i < 8; i++) vals[i] = '0;
            4: for (int i = 0; i < 8; i++) vals[i] = '1;
            // every band empty
            5: begin
                vals[REG_ONE_BAND_MIN]  = ONE_BAND_MAX_RST;
                vals[REG_ONE_BAND_MAX]  = ONE_BAND_MIN_RST;
                vals[REG_ZERO_BAND_MIN] = ZERO_BAND_MAX_RST;
                vals[REG_ZERO_BAND_MAX] = ZERO_BAND_MIN_RST;
                vals[REG_TOTAL_MIN]     = TOTAL_MAX_RST;
                vals[REG_TOTAL_MAX]     = TOTAL_MIN_RST;
            end
            6: for (int i = 0; i < 8; i++) vals[i] = CFG_W'($urandom);
            default: ;
        endcase
        // junk above the 16-bit thresholds must be dropped
        for (int i = 0; i < 6; i++)
            vals[i] = {CFG_W'($urandom_range(3)) << THR_W} | {2'b00, vals[i][THR_W-1:0]};
        for (int i = 0; i < 8; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_index_t'(i);
            cfg_data  <= vals[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            @(negedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    // one random phase: mostly well-formed bits, some noise and broken bits
    task automatic run_random_phase(input int waves, input logic pause_midway);
        logic [IN_W-1:0] bit_waves [4];
        int              sent;
        int              kind_pick;
        int              thin_slot;
        sent = 0;
        while (sent < waves) begin
            if (pause_midway && sent >= waves / 2 && sent < waves / 2 + 4) begin
                wait_idle();
                pause_midway = 1'b0;
            end
            kind_pick = $urandom_range(99);
            if (kind_pick < 40) begin
                bit_waves[0] = pick(thr.zero_long_min, int'(thr.zero_long_min) + 400);
                bit_waves[1] = pick(thr.zero_band_min, int'(thr.zero_band_max) - 1);
                if ($urandom_range(1)) begin
                    push_wave(bit_waves[0]);
                    push_wave(bit_waves[1]);
                end else begin
                    push_wave(bit_waves[1]);
                    push_wave(bit_waves[0]);
                end
                sent += 2;
            end else if (kind_pick < 88) begin
                thin_slot = $urandom_range(3);
                for (int i = 0; i < 4; i++)
                    bit_waves[i] = (i == thin_slot) ?
                        pick(thr.one_band_min, int'(thr.one_short_lim) - 1) :
                        pick(thr.one_band_min, int'(thr.one_band_max) - 1);
                // broken bit: one half-wave pushed just outside the one band
                if (kind_pick >= 76)
                    bit_waves[$urandom_range(3)] = $urandom_range(1) ?
                        pick(thr.one_band_max, int'(thr.one_band_max) + 200) :
                        pick(int'(thr.one_band_min) - 1, int'(thr.one_band_min) - 1);
                for (int i = 0; i < 4; i++) push_wave(bit_waves[i]);
                sent += 4;
            end else begin
                push_wave(IN_W'($urandom));
                sent++;
            end
        end
    endtask

    // main sequence
    initial begin : stimulus
        int spins;
        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_half_wave_length = '0;
        m_ready            = 1'b0;
        cfg_valid          = 1'b0;
        cfg_index          = REG_ONE_BAND_MIN;
        cfg_data           = '0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        error_count        = 0;
        symbol_count       = 0;
        wave_count         = 0;
        for (int i = 0; i < WIN_SIZE; i++) wave_win[i] = '0;
        thr.one_band_min  = ONE_BAND_MIN_RST;
        thr.one_short_lim = ONE_SHORT_LIM_RST;
        thr.one_band_max  = ONE_BAND_MAX_RST;
        thr.zero_band_min = ZERO_BAND_MIN_RST;
        thr.zero_long_min = ZERO_LONG_MIN_RST;
        thr.zero_band_max = ZERO_BAND_MAX_RST;
        thr.total_min     = TOTAL_MIN_RST;
        thr.total_max     = TOTAL_MAX_RST;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed rows at the reset thresholds
        foreach (directed_rows[r]) begin
            spins = symbol_count;
            push_wave(directed_rows[r].len);
            if (directed_rows[r].checked) begin
                if (symbol_count == spins) begin
                    $error("row %0d completed no symbol", r);
                    error_count++;
                end else begin
                    if (last_symbol.kind !== directed_rows[r].kind) begin
                        $error("row %0d symbol_kind expected %0d actual %0d",
                               r, directed_rows[r].kind, last_symbol.kind);
                        error_count++;
                    end
                    if (last_symbol.length !== directed_rows[r].length) begin
                        $error("row %0d symbol_length expected %0d actual %0d",
                               r, directed_rows[r].length, last_symbol.length);
                        error_count++;
                    end
                end
            end
        end

        // random phases, each under its own threshold set and one of four idle profiles
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_idle();
            load_thresholds(p);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            run_random_phase(PHASE_WAVES, p == 2);
        end
        s_valid <= 1'b0;

        // drain
        spins = 0;
        while (pending_symbols.size() > 0 && spins < 100000) begin
            @(negedge aclk);
            spins++;
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (pending_symbols.size() > 0) begin
            $error("%0d symbols never arrived", pending_symbols.size());
            error_count++;
        end

        if (error_count == 0) begin
            $display("PASS tape_half_wave_bit_classifier");
        end else begin
            $display("FAIL tape_half_wave_bit_classifier");
        end
        $finish;
    end

endmodule

### tape_half_wave_bit_classifier.f
hdl/hwbc_pkg.sv
hdl/hwbc_cfg_regs.sv
hdl/hwbc_classify.sv
hdl/tape_half_wave_bit_classifier.sv
hdl/hwbc_checker.sv
dv/testbench.sv
